// ===== src/rod_pkg.sv =====
// ----------------------------------------------------------------------------
// rod_pkg
// Shared widths, register map and payload types for the rectangle overlap
// and edge distance block.
// ----------------------------------------------------------------------------
package rod_pkg;

   localparam int POS_W   = 24;  // signed positions
   localparam int SIZE_W  = 16;  // unsigned width / length
   localparam int EPS_W   = 16;  // touch epsilon
   localparam int CTR_W   = 25;  // signed edges and centers
   localparam int DIFF_W  = 27;  // signed differences
   localparam int MAG_W   = 26;  // magnitudes of differences
   localparam int GAP_W   = 25;  // per-axis edge gap
   localparam int SQ_W    = 50;  // squared gaps and their sum
   localparam int ROOT_W  = 25;  // edge distance
   localparam int TRIAL_W = 52;  // square root trial term
   localparam int DATA_W  = 32;  // csr data
   localparam int ADDR_W  = 3;   // csr byte address

   localparam logic             REG_TOUCH_EPS = 1'b0;  // word select paddr[2]
   localparam logic [EPS_W-1:0] EPS_RESET     = 16'd1;

   typedef struct packed {
      logic signed [POS_W-1:0] a_x;
      logic signed [POS_W-1:0] a_z;
      logic [SIZE_W-1:0]       a_width;
      logic [SIZE_W-1:0]       a_length;
      logic                    a_centered;
      logic signed [POS_W-1:0] b_x;
      logic signed [POS_W-1:0] b_z;
      logic [SIZE_W-1:0]       b_width;
      logic [SIZE_W-1:0]       b_length;
      logic                    b_centered;
   } req_type;

   typedef struct packed {
      logic overlapping;
      logic touch_top;
      logic touch_bottom;
      logic touch_left;
      logic touch_right;
   } side_type;

   typedef struct packed {
      logic              overlapping;
      logic [ROOT_W-1:0] edge_distance;
      logic              touch_top;
      logic              touch_bottom;
      logic              touch_left;
      logic              touch_right;
   } rsp_type;

endpackage

// ===== src/rod_if.sv =====
// ----------------------------------------------------------------------------
// rod_req_if / rod_rsp_if
// Valid/ready channels for rectangle pairs and for their results.
// ----------------------------------------------------------------------------
interface rod_req_if;
   logic                             valid;
   logic                             ready;
   logic signed [rod_pkg::POS_W-1:0] a_x;
   logic signed [rod_pkg::POS_W-1:0] a_z;
   logic [rod_pkg::SIZE_W-1:0]       a_width;
   logic [rod_pkg::SIZE_W-1:0]       a_length;
   logic                             a_centered;
   logic signed [rod_pkg::POS_W-1:0] b_x;
   logic signed [rod_pkg::POS_W-1:0] b_z;
   logic [rod_pkg::SIZE_W-1:0]       b_width;
   logic [rod_pkg::SIZE_W-1:0]       b_length;
   logic                             b_centered;

   modport source (output valid, a_x, a_z, a_width, a_length, a_centered,
                   b_x, b_z, b_width, b_length, b_centered, input ready);
   modport sink (input valid, a_x, a_z, a_width, a_length, a_centered,
                 b_x, b_z, b_width, b_length, b_centered, output ready);
   modport monitor (input valid, ready, a_x, a_z, a_width, a_length, a_centered,
                    b_x, b_z, b_width, b_length, b_centered);
endinterface

interface rod_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        overlapping;
   logic [rod_pkg::ROOT_W-1:0]  edge_distance;
   logic                        touch_top;
   logic                        touch_bottom;
   logic                        touch_left;
   logic                        touch_right;

   modport source (output valid, overlapping, edge_distance, touch_top,
                   touch_bottom, touch_left, touch_right, input ready);
   modport sink (input valid, overlapping, edge_distance, touch_top,
                 touch_bottom, touch_left, touch_right, output ready);
   modport monitor (input valid, ready, overlapping, edge_distance, touch_top,
                    touch_bottom, touch_left, touch_right);
endinterface

// ===== src/rod_csr.sv =====
// ----------------------------------------------------------------------------
// rod_csr
// APB register file holding the touch epsilon.
// ----------------------------------------------------------------------------
module rod_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [rod_pkg::ADDR_W-1:0]   paddr,
   input  logic [rod_pkg::DATA_W-1:0]   pwdata,
   output logic [rod_pkg::DATA_W-1:0]   prdata,
   output logic                         pready,
   output logic [rod_pkg::EPS_W-1:0]    touch_eps
);

   logic [rod_pkg::EPS_W-1:0] eps_ff;
   logic [rod_pkg::EPS_W-1:0] eps_in;
   logic                      hit;

   assign hit    = (paddr[2] == rod_pkg::REG_TOUCH_EPS);
   assign eps_in = (psel && penable && pwrite && hit) ? pwdata[rod_pkg::EPS_W-1:0] : eps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= rod_pkg::EPS_RESET;
      end else begin
         eps_ff <= eps_in;
      end
   end

   assign pready    = 1'b1;
   assign prdata    = hit ? rod_pkg::DATA_W'(eps_ff) : '0;
   assign touch_eps = eps_ff;

endmodule

// ===== src/rod_geom.sv =====
// ----------------------------------------------------------------------------
// rod_geom
// Six-stage front end: edges and centers, differences, magnitudes, gaps and
// touch tests, squared gaps, and their sum.
// ----------------------------------------------------------------------------
module rod_geom (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  rod_pkg::req_type           in_data,
   input  logic [rod_pkg::EPS_W-1:0]  touch_eps,
   output logic                       out_valid,
   output logic [rod_pkg::SQ_W-1:0]   out_sum,
   output rod_pkg::side_type          out_side
);

   localparam int HALF_W = rod_pkg::SIZE_W - 1;

   logic [5:0] v_ff;
   logic [5:0] v_in;

   // stage 1
   logic signed [rod_pkg::CTR_W-1:0] a_left_ff, a_top_ff, b_left_ff, b_top_ff;
   logic signed [rod_pkg::CTR_W-1:0] a_cx_ff, a_cz_ff, b_cx_ff, b_cz_ff;
   logic signed [rod_pkg::CTR_W-1:0] a_left_in, a_top_in, b_left_in, b_top_in;
   logic signed [rod_pkg::CTR_W-1:0] a_cx_in, a_cz_in, b_cx_in, b_cz_in;
   logic [rod_pkg::SIZE_W-1:0] hw1_ff, hl1_ff, hw1_in, hl1_in;
   logic [rod_pkg::SIZE_W-1:0] aw_ff, al_ff, bw_ff, bl_ff;
   logic [HALF_W-1:0] a_hw, a_hl, b_hw, b_hl;
   logic signed [rod_pkg::CTR_W-1:0] ax, az, bx, bz;

   // stage 2
   logic signed [rod_pkg::DIFF_W-1:0] dx_ff, dz_ff, et_ff, eb_ff, el_ff, er_ff;
   logic signed [rod_pkg::DIFF_W-1:0] dx_in, dz_in, et_in, eb_in, el_in, er_in;
   logic [rod_pkg::SIZE_W-1:0] hw2_ff, hl2_ff;

   // stage 3
   logic [rod_pkg::MAG_W-1:0] mx_ff, mz_ff, mt_ff, mb_ff, ml_ff, mr_ff;
   logic [rod_pkg::MAG_W-1:0] mx_in, mz_in, mt_in, mb_in, ml_in, mr_in;
   logic [rod_pkg::SIZE_W-1:0] hw3_ff, hl3_ff;

   // stage 4
   logic [rod_pkg::GAP_W-1:0] gx_ff, gz_ff, gx_in, gz_in;
   rod_pkg::side_type side4_ff, side4_in, side5_ff, side6_ff;
   logic [rod_pkg::MAG_W-1:0] hw_m, hl_m, eps_m;

   // stage 5, 6
   logic [rod_pkg::SQ_W-1:0] sqx_ff, sqz_ff, sqx_in, sqz_in, sum_ff, sum_in;

   function automatic logic [rod_pkg::MAG_W-1:0] mag(
      input logic signed [rod_pkg::DIFF_W-1:0] d);
      logic [rod_pkg::DIFF_W-1:0] n;
      n = -d;
      return d[rod_pkg::DIFF_W-1] ? n[rod_pkg::MAG_W-1:0] : d[rod_pkg::MAG_W-1:0];
   endfunction

   assign v_in = {v_ff[4:0], in_valid};

   assign a_hw = in_data.a_width[rod_pkg::SIZE_W-1:1];
   assign a_hl = in_data.a_length[rod_pkg::SIZE_W-1:1];
   assign b_hw = in_data.b_width[rod_pkg::SIZE_W-1:1];
   assign b_hl = in_data.b_length[rod_pkg::SIZE_W-1:1];
   assign ax   = rod_pkg::CTR_W'(in_data.a_x);
   assign az   = rod_pkg::CTR_W'(in_data.a_z);
   assign bx   = rod_pkg::CTR_W'(in_data.b_x);
   assign bz   = rod_pkg::CTR_W'(in_data.b_z);

   assign a_left_in = in_data.a_centered ? ax - rod_pkg::CTR_W'(a_hw) : ax;
   assign a_top_in  = in_data.a_centered ? az - rod_pkg::CTR_W'(a_hl) : az;
   assign b_left_in = in_data.b_centered ? bx - rod_pkg::CTR_W'(b_hw) : bx;
   assign b_top_in  = in_data.b_centered ? bz - rod_pkg::CTR_W'(b_hl) : bz;
   assign a_cx_in   = in_data.a_centered ? ax : ax + rod_pkg::CTR_W'(a_hw);
   assign a_cz_in   = in_data.a_centered ? az : az + rod_pkg::CTR_W'(a_hl);
   assign b_cx_in   = in_data.b_centered ? bx : bx + rod_pkg::CTR_W'(b_hw);
   assign b_cz_in   = in_data.b_centered ? bz : bz + rod_pkg::CTR_W'(b_hl);
   assign hw1_in    = rod_pkg::SIZE_W'(({1'b0, in_data.a_width} + {1'b0, in_data.b_width}) >> 1);
   assign hl1_in    = rod_pkg::SIZE_W'(({1'b0, in_data.a_length} + {1'b0, in_data.b_length}) >> 1);

   assign dx_in = rod_pkg::DIFF_W'(a_cx_ff) - rod_pkg::DIFF_W'(b_cx_ff);
   assign dz_in = rod_pkg::DIFF_W'(a_cz_ff) - rod_pkg::DIFF_W'(b_cz_ff);
   assign et_in = rod_pkg::DIFF_W'(a_top_ff) - rod_pkg::DIFF_W'(b_top_ff)
                  - rod_pkg::DIFF_W'(bl_ff);
   assign eb_in = rod_pkg::DIFF_W'(b_top_ff) - rod_pkg::DIFF_W'(a_top_ff)
                  - rod_pkg::DIFF_W'(al_ff);
   assign el_in = rod_pkg::DIFF_W'(a_left_ff) - rod_pkg::DIFF_W'(b_left_ff)
                  - rod_pkg::DIFF_W'(bw_ff);
   assign er_in = rod_pkg::DIFF_W'(b_left_ff) - rod_pkg::DIFF_W'(a_left_ff)
                  - rod_pkg::DIFF_W'(aw_ff);

   assign mx_in = mag(dx_ff);
   assign mz_in = mag(dz_ff);
   assign mt_in = mag(et_ff);
   assign mb_in = mag(eb_ff);
   assign ml_in = mag(el_ff);
   assign mr_in = mag(er_ff);

   assign hw_m  = rod_pkg::MAG_W'(hw3_ff);
   assign hl_m  = rod_pkg::MAG_W'(hl3_ff);
   assign eps_m = rod_pkg::MAG_W'(touch_eps);
   assign gx_in = (mx_ff > hw_m) ? rod_pkg::GAP_W'(mx_ff - hw_m) : '0;
   assign gz_in = (mz_ff > hl_m) ? rod_pkg::GAP_W'(mz_ff - hl_m) : '0;
   assign side4_in.overlapping  = (mx_ff <= hw_m) && (mz_ff <= hl_m);
   assign side4_in.touch_top    = mt_ff < eps_m;
   assign side4_in.touch_bottom = mb_ff < eps_m;
   assign side4_in.touch_left   = ml_ff < eps_m;
   assign side4_in.touch_right  = mr_ff < eps_m;

   assign sqx_in = gx_ff * gx_ff;
   assign sqz_in = gz_ff * gz_ff;
   assign sum_in = rod_pkg::SQ_W'(sqx_ff + sqz_ff);  // below 2^50 by range

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_left_ff <= a_left_in;
         a_top_ff  <= a_top_in;
         b_left_ff <= b_left_in;
         b_top_ff  <= b_top_in;
         a_cx_ff   <= a_cx_in;
         a_cz_ff   <= a_cz_in;
         b_cx_ff   <= b_cx_in;
         b_cz_ff   <= b_cz_in;
         hw1_ff    <= hw1_in;
         hl1_ff    <= hl1_in;
         aw_ff     <= in_data.a_width;
         al_ff     <= in_data.a_length;
         bw_ff     <= in_data.b_width;
         bl_ff     <= in_data.b_length;
         dx_ff     <= dx_in;
         dz_ff     <= dz_in;
         et_ff     <= et_in;
         eb_ff     <= eb_in;
         el_ff     <= el_in;
         er_ff     <= er_in;
         hw2_ff    <= hw1_ff;
         hl2_ff    <= hl1_ff;
         mx_ff     <= mx_in;
         mz_ff     <= mz_in;
         mt_ff     <= mt_in;
         mb_ff     <= mb_in;
         ml_ff     <= ml_in;
         mr_ff     <= mr_in;
         hw3_ff    <= hw2_ff;
         hl3_ff    <= hl2_ff;
         gx_ff     <= gx_in;
         gz_ff     <= gz_in;
         side4_ff  <= side4_in;
         sqx_ff    <= sqx_in;
         sqz_ff    <= sqz_in;
         side5_ff  <= side4_ff;
         sum_ff    <= sum_in;
         side6_ff  <= side5_ff;
      end
   end

   assign out_valid = v_ff[5];
   assign out_sum   = sum_ff;
   assign out_side  = side6_ff;

endmodule

// ===== src/rod_isqrt.sv =====
// ----------------------------------------------------------------------------
// rod_isqrt
// Pipelined floor square root, one root bit per stage.
// ----------------------------------------------------------------------------
module rod_isqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [rod_pkg::SQ_W-1:0]     in_sum,
   input  rod_pkg::side_type            in_side,
   output logic                         out_valid,
   output logic [rod_pkg::ROOT_W-1:0]   out_root,
   output rod_pkg::side_type            out_side
);

   localparam int N = rod_pkg::ROOT_W;

   logic [N-1:0]               v_ff;
   logic [rod_pkg::SQ_W-1:0]   rem_ff [N];
   logic [rod_pkg::SQ_W-1:0]   rem_in [N];
   logic [N-1:0]               q_ff   [N];
   logic [N-1:0]               q_in   [N];
   rod_pkg::side_type          side_ff [N];

   logic [rod_pkg::SQ_W-1:0]   rem_s  [N];
   logic [N-1:0]               q_s    [N];
   rod_pkg::side_type          side_s [N];
   logic [N-1:0]               v_s;

   assign rem_s[0]  = in_sum;
   assign q_s[0]    = '0;
   assign side_s[0] = in_side;
   assign v_s[0]    = in_valid;

   for (genvar k = 0; k < N; k++) begin : g_stage
      localparam int BIT = N - 1 - k;
      logic [rod_pkg::TRIAL_W-1:0] trial;
      logic [rod_pkg::TRIAL_W-1:0] rem_x;
      logic                        fits;

      if (k > 0) begin : g_link
         assign rem_s[k]  = rem_ff[k-1];
         assign q_s[k]    = q_ff[k-1];
         assign side_s[k] = side_ff[k-1];
         assign v_s[k]    = v_ff[k-1];
      end

      // (2q + 2^BIT) * 2^BIT, where q holds only bits above BIT
      assign trial = (rod_pkg::TRIAL_W'(q_s[k]) << (BIT + 1))
                   | (rod_pkg::TRIAL_W'(1) << (2 * BIT));
      assign rem_x = rod_pkg::TRIAL_W'(rem_s[k]);
      assign fits  = rem_x >= trial;
      assign rem_in[k] = fits ? rod_pkg::SQ_W'(rem_x - trial) : rem_s[k];
      assign q_in[k]   = fits ? (q_s[k] | (N'(1) << BIT)) : q_s[k];

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_s[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in[k];
            q_ff[k]    <= q_in[k];
            side_ff[k] <= side_s[k];
         end
      end
   end

   assign out_valid = v_ff[N-1];
   assign out_root  = q_ff[N-1];
   assign out_side  = side_ff[N-1];

endmodule

// ===== src/rod_skid.sv =====
// ----------------------------------------------------------------------------
// rod_skid
// Output register with one skid entry; the pipeline advances while the skid
// entry is empty.
// ----------------------------------------------------------------------------
module rod_skid (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  rod_pkg::rsp_type   in_data,
   output logic               in_ready,
   output logic               out_valid,
   output rod_pkg::rsp_type   out_data,
   input  logic               out_ready
);

   logic             out_v_ff, out_v_in, skid_v_ff, skid_v_in;
   rod_pkg::rsp_type out_d_ff, out_d_in, skid_d_ff, skid_d_in;

   always_comb begin
      if (!out_v_ff || out_ready) begin
         out_v_in  = skid_v_ff || in_valid;
         out_d_in  = skid_v_ff ? skid_d_ff : in_data;
         skid_v_in = 1'b0;
         skid_d_in = skid_d_ff;
      end else begin
         out_v_in  = 1'b1;
         out_d_in  = out_d_ff;
         skid_v_in = skid_v_ff || in_valid;
         skid_d_in = skid_v_ff ? skid_d_ff : in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_d_ff  <= out_d_in;
      skid_d_ff <= skid_d_in;
   end

   assign in_ready  = !skid_v_ff;
   assign out_valid = out_v_ff;
   assign out_data  = out_d_ff;

endmodule

// ===== src/rect_overlap_distance.sv =====
// ----------------------------------------------------------------------------
// rect_overlap_distance
// Overlap flag, edge gap distance and edge touch flags for a pair of
// axis-aligned rectangles.
// ----------------------------------------------------------------------------
// Takes one rectangle pair per cycle while req ready is high and returns one
// result beat per pair, in order. The path holds 32 registers: six geometry
// stages (edges, differences, magnitudes, gaps, squares, sum), 25 square-root
// stages that each settle one bit of the distance, and the output register.
// The whole pipeline holds while the one-entry skid behind the output
// register is full, so req ready drops only once a stalled rsp beat has a
// second result queued behind it. touch_epsilon is sampled in the gap stage;
// change it only while no pair is in flight.
// ----------------------------------------------------------------------------
module rect_overlap_distance (
   input  logic                        clock,
   input  logic                        reset,
   rod_req_if.sink                     req_chan,
   rod_rsp_if.source                   rsp_chan,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [rod_pkg::ADDR_W-1:0]  paddr,
   input  logic [rod_pkg::DATA_W-1:0]  pwdata,
   output logic [rod_pkg::DATA_W-1:0]  prdata,
   output logic                        pready
);

   logic                       en;
   logic [rod_pkg::EPS_W-1:0]  touch_eps;
   rod_pkg::req_type           req_data;
   logic                       geo_valid;
   logic [rod_pkg::SQ_W-1:0]   geo_sum;
   rod_pkg::side_type          geo_side;
   logic                       sq_valid;
   logic [rod_pkg::ROOT_W-1:0] sq_root;
   rod_pkg::side_type          sq_side;
   rod_pkg::rsp_type           res_data;
   rod_pkg::rsp_type           out_data;

   assign req_data.a_x        = req_chan.a_x;
   assign req_data.a_z        = req_chan.a_z;
   assign req_data.a_width    = req_chan.a_width;
   assign req_data.a_length   = req_chan.a_length;
   assign req_data.a_centered = req_chan.a_centered;
   assign req_data.b_x        = req_chan.b_x;
   assign req_data.b_z        = req_chan.b_z;
   assign req_data.b_width    = req_chan.b_width;
   assign req_data.b_length   = req_chan.b_length;
   assign req_data.b_centered = req_chan.b_centered;
   assign req_chan.ready      = en;

   rod_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .touch_eps (touch_eps)
   );

   rod_geom u_geom (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_chan.valid),
      .in_data   (req_data),
      .touch_eps (touch_eps),
      .out_valid (geo_valid),
      .out_sum   (geo_sum),
      .out_side  (geo_side)
   );

   rod_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (geo_valid),
      .in_sum    (geo_sum),
      .in_side   (geo_side),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   assign res_data.overlapping   = sq_side.overlapping;
   assign res_data.edge_distance = sq_root;
   assign res_data.touch_top     = sq_side.touch_top;
   assign res_data.touch_bottom  = sq_side.touch_bottom;
   assign res_data.touch_left    = sq_side.touch_left;
   assign res_data.touch_right   = sq_side.touch_right;

   rod_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_data   (res_data),
      .in_ready  (en),
      .out_valid (rsp_chan.valid),
      .out_data  (out_data),
      .out_ready (rsp_chan.ready)
   );

   assign rsp_chan.overlapping   = out_data.overlapping;
   assign rsp_chan.edge_distance = out_data.edge_distance;
   assign rsp_chan.touch_top     = out_data.touch_top;
   assign rsp_chan.touch_bottom  = out_data.touch_bottom;
   assign rsp_chan.touch_left    = out_data.touch_left;
   assign rsp_chan.touch_right   = out_data.touch_right;

endmodule

// ===== src/rod_checker.sv =====
// ----------------------------------------------------------------------------
// rod_checker
// Port-level checks on the result and request channels, bound to the top level.
// ----------------------------------------------------------------------------
module rod_checker (
   input logic        clock,
   input logic        reset,
   rod_req_if.sink    req_chan,
   rod_rsp_if.source  rsp_chan
);

   // no result leaves right after reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("rsp valid right after reset");

   // an overlapping pair has zero edge distance
   a_overlap_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.overlapping |-> rsp_chan.edge_distance == '0)
      else $error("overlap with nonzero edge distance");

   // input only backs up once a result is waiting
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> rsp_chan.valid)
      else $error("req stalled with no rsp pending");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |=> rsp_chan.valid
         && $stable(rsp_chan.edge_distance) && $stable(rsp_chan.overlapping))
      else $error("stalled rsp beat changed");

endmodule

bind rect_overlap_distance rod_checker u_rod_checker (
   .clock    (clock),
   .reset    (reset),
   .req_chan (req_chan),
   .rsp_chan (rsp_chan)
);

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks rect_overlap_distance against an in-bench predictor of the overlap
// flag, edge distance and touch flags. Pairs are driven on the req channel
// with random gaps and results are taken under random rsp stalls. Each result
// beat is compared field by field with the oldest prediction. touch_epsilon
// is reprogrammed over the APB port between phases and read back.
// ----------------------------------------------------------------------------
module testbench;

   localparam int DRAIN_CYCLES     = 40;   // pipeline is 32 deep
   localparam int RANDOM_PER_PHASE = 150;
   localparam int NUM_PHASES       = 7;

   localparam logic [rod_pkg::ADDR_W-1:0] EPS_ADDR      = {rod_pkg::REG_TOUCH_EPS, 2'b00};
   localparam logic [rod_pkg::ADDR_W-1:0] UNMAPPED_ADDR = {~rod_pkg::REG_TOUCH_EPS, 2'b00};

   logic clock = 1'b0;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [rod_pkg::ADDR_W-1:0] paddr;
   logic [rod_pkg::DATA_W-1:0] pwdata;
   logic [rod_pkg::DATA_W-1:0] prdata;
   logic pready;

   rod_req_if req_bus ();
   rod_rsp_if rsp_bus ();

   rect_overlap_distance dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   rod_pkg::rsp_type          due_results[$];
   logic [rod_pkg::EPS_W-1:0] touch_eps;
   int                        fault_count;
   int                        req_idle_pct;
   int                        rsp_stall_pct;
   int                        stall_left;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5000000;
      $display("FAIL");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   function automatic longint abs_gap(longint u, longint v);
      return (u > v) ? u - v : v - u;
   endfunction

   function automatic longint floor_root(longint n);
      longint r;
      longint t;
      r = 0;
      for (int b = rod_pkg::ROOT_W; b >= 0; b--) begin
         t = r | (longint'(1) << b);
         if (t * t <= n) r = t;
      end
      return r;
   endfunction

   function automatic rod_pkg::rsp_type predict_rect_pair(rod_pkg::req_type p);
      rod_pkg::rsp_type r;
      longint  ax, az, bx, bz, aw, al, bw, bl, eps;
      longint  a_left, a_top, b_left, b_top;
      longint  dx, dz, hw, hl, gx, gz, root;
      ax  = longint'($signed(p.a_x));
      az  = longint'($signed(p.a_z));
      bx  = longint'($signed(p.b_x));
      bz  = longint'($signed(p.b_z));
      aw  = longint'(p.a_width);
      al  = longint'(p.a_length);
      bw  = longint'(p.b_width);
      bl  = longint'(p.b_length);
      eps = longint'(touch_eps);
      a_left = p.a_centered ? ax - aw / 2 : ax;
      a_top  = p.a_centered ? az - al / 2 : az;
      b_left = p.b_centered ? bx - bw / 2 : bx;
      b_top  = p.b_centered ? bz - bl / 2 : bz;
      dx = abs_gap(a_left + aw / 2, b_left + bw / 2);
      dz = abs_gap(a_top + al / 2, b_top + bl / 2);
      hw = (aw + bw) / 2;
      hl = (al + bl) / 2;
      r.overlapping = (dx <= hw) && (dz <= hl);
      root = 0;
      if (!r.overlapping) begin
         gx   = (dx > hw) ? dx - hw : 0;
         gz   = (dz > hl) ? dz - hl : 0;
         root = floor_root(gx * gx + gz * gz);
      end
      r.edge_distance = root[rod_pkg::ROOT_W-1:0];
      r.touch_top     = abs_gap(a_top, b_top + bl) < eps;
      r.touch_bottom  = abs_gap(b_top, a_top + al) < eps;
      r.touch_left    = abs_gap(a_left, b_left + bw) < eps;
      r.touch_right   = abs_gap(b_left, a_left + aw) < eps;
      return r;
   endfunction

   // ------------------------------------------------------------ pair makers

   function automatic rod_pkg::req_type make_pair(int ax, int az, int aw, int al, bit ac,
                                                  int bx, int bz, int bw, int bl, bit bc);
      rod_pkg::req_type p;
      p.a_x = rod_pkg::POS_W'(ax);   p.a_z = rod_pkg::POS_W'(az);
      p.a_width = rod_pkg::SIZE_W'(aw);   p.a_length = rod_pkg::SIZE_W'(al);
      p.a_centered = ac;
      p.b_x = rod_pkg::POS_W'(bx);   p.b_z = rod_pkg::POS_W'(bz);
      p.b_width = rod_pkg::SIZE_W'(bw);   p.b_length = rod_pkg::SIZE_W'(bl);
      p.b_centered = bc;
      return p;
   endfunction

   function automatic rod_pkg::req_type full_random_pair();
      rod_pkg::req_type p;
      p.a_x = rod_pkg::POS_W'($urandom);   p.a_z = rod_pkg::POS_W'($urandom);
      p.a_width = rod_pkg::SIZE_W'($urandom);   p.a_length = rod_pkg::SIZE_W'($urandom);
      p.a_centered = $urandom_range(1);
      p.b_x = rod_pkg::POS_W'($urandom);   p.b_z = rod_pkg::POS_W'($urandom);
      p.b_width = rod_pkg::SIZE_W'($urandom);   p.b_length = rod_pkg::SIZE_W'($urandom);
      p.b_centered = $urandom_range(1);
      return p;
   endfunction

   function automatic int random_size(int tiny);
      if (tiny != 0) return $urandom_range(0, 64);
      if ($urandom_range(9) == 0) return $urandom_range(0, 65535);
      return $urandom_range(0, 300);
   endfunction

   function automatic longint place_edge(longint lo, longint a_sz, longint b_sz,
                                         longint span);
      longint d;
      d = longint'($urandom_range(0, 2 * span)) - span;
      case ($urandom_range(3))
         0: return lo + a_sz + d;       // b just past a's far edge
         1: return lo - b_sz + d;       // b just before a's near edge
         2: return lo + d;
         default: return lo + longint'($urandom_range(0, 2000)) - 1000;
      endcase
   endfunction

   // pairs placed so that edges land close to each other, tiny = dense clusters
   function automatic rod_pkg::req_type near_pair(int tiny);
      rod_pkg::req_type p;
      longint  span, a_left, a_top, b_left, b_top;
      int      range_half;
      range_half = tiny ? 64 : (1 << 20);
      span = (tiny || touch_eps > 200) ? 200 : longint'(touch_eps) + 2;
      if (!tiny && $urandom_range(3) == 0) span = longint'(touch_eps) + 2;
      p.a_x = rod_pkg::POS_W'(int'($urandom_range(0, 2 * range_half)) - range_half);
      p.a_z = rod_pkg::POS_W'(int'($urandom_range(0, 2 * range_half)) - range_half);
      p.a_width    = rod_pkg::SIZE_W'(random_size(tiny));
      p.a_length   = rod_pkg::SIZE_W'(random_size(tiny));
      p.a_centered = $urandom_range(1);
      p.b_width    = rod_pkg::SIZE_W'(random_size(tiny));
      p.b_length   = rod_pkg::SIZE_W'(random_size(tiny));
      p.b_centered = $urandom_range(1);
      a_left = longint'($signed(p.a_x)) - (p.a_centered ? p.a_width / 2 : 0);
      a_top  = longint'($signed(p.a_z)) - (p.a_centered ? p.a_length / 2 : 0);
      b_left = place_edge(a_left, p.a_width, p.b_width, span);
      b_top  = place_edge(a_top, p.a_length, p.b_length, span);
      p.b_x = rod_pkg::POS_W'(b_left + (p.b_centered ? p.b_width / 2 : 0));
      p.b_z = rod_pkg::POS_W'(b_top + (p.b_centered ? p.b_length / 2 : 0));
      return p;
   endfunction

   // ------------------------------------------------------------- stimulus

   function automatic int pick_gap(int pct);
      if ($urandom_range(99) >= pct) return 0;
      if ($urandom_range(9) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   task automatic drive_payload(rod_pkg::req_type p);
      req_bus.a_x = p.a_x;
      req_bus.a_z = p.a_z;
      req_bus.a_width = p.a_width;
      req_bus.a_length = p.a_length;
      req_bus.a_centered = p.a_centered;
      req_bus.b_x = p.b_x;
      req_bus.b_z = p.b_z;
      req_bus.b_width = p.b_width;
      req_bus.b_length = p.b_length;
      req_bus.b_centered = p.b_centered;
   endtask

   task automatic send_pair(rod_pkg::req_type p);
      int gap;
      gap = pick_gap(req_idle_pct);
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid = 1'b0;
         drive_payload(full_random_pair());
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      drive_payload(p);
      req_bus.valid = 1'b1;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [rod_pkg::ADDR_W-1:0] addr,
                             input logic [rod_pkg::DATA_W-1:0] wdata,
                             output logic [rod_pkg::DATA_W-1:0] rdata);
      @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = wr;
      paddr = addr;
      pwdata = wdata;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      rdata = prdata;
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   task automatic check_epsilon_readback();
      logic [rod_pkg::DATA_W-1:0] rd;
      csr_access(1'b0, EPS_ADDR, '0, rd);
      if (rd[rod_pkg::EPS_W-1:0] !== touch_eps) begin
         $error("touch_epsilon readback: expected %0d, actual %0d",
                touch_eps, rd[rod_pkg::EPS_W-1:0]);
         fault_count++;
      end
   endtask

   // only while nothing is in flight
   task automatic program_epsilon(logic [rod_pkg::ADDR_W-1:0] addr,
                                  logic [rod_pkg::DATA_W-1:0] value);
      logic [rod_pkg::DATA_W-1:0] rd;
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_access(1'b1, addr, value, rd);
      if (addr == EPS_ADDR) touch_eps = value[rod_pkg::EPS_W-1:0];
      check_epsilon_readback();
   endtask

   // ------------------------------------------------------------- checking

   task automatic check_field(string name, longint want, longint got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fault_count++;
      end
   endtask

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_bus.ready = 1'b0;
         stall_left--;
      end else begin
         stall_left = pick_gap(rsp_stall_pct);
         rsp_bus.ready = (stall_left == 0);
         if (stall_left > 0) stall_left--;
      end
   end

   always @(posedge clock) begin
      rod_pkg::req_type pair;
      rod_pkg::rsp_type want;
      if (reset === 1'b0) begin
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready) begin
            if (due_results.size() == 0) begin
               $error("result beat with no pair outstanding");
               fault_count++;
            end else begin
               want = due_results.pop_front();
               check_field("overlapping", want.overlapping, rsp_bus.overlapping);
               check_field("edge_distance", want.edge_distance, rsp_bus.edge_distance);
               check_field("touch_top", want.touch_top, rsp_bus.touch_top);
               check_field("touch_bottom", want.touch_bottom, rsp_bus.touch_bottom);
               check_field("touch_left", want.touch_left, rsp_bus.touch_left);
               check_field("touch_right", want.touch_right, rsp_bus.touch_right);
            end
         end
         if (req_bus.valid && req_bus.ready === 1'b1) begin
            pair.a_x = req_bus.a_x;
            pair.a_z = req_bus.a_z;
            pair.a_width = req_bus.a_width;
            pair.a_length = req_bus.a_length;
            pair.a_centered = req_bus.a_centered;
            pair.b_x = req_bus.b_x;
            pair.b_z = req_bus.b_z;
            pair.b_width = req_bus.b_width;
            pair.b_length = req_bus.b_length;
            pair.b_centered = req_bus.b_centered;
            due_results.push_back(predict_rect_pair(pair));
         end
      end
   end

   // ---------------------------------------------------------------- tests

   task automatic test_reset_epsilon();
      check_epsilon_readback();
      req_idle_pct = 30;
      rsp_stall_pct = 30;
      send_pair(make_pair(0, 0, 10, 10, 0, 10, 0, 10, 10, 0));
      send_pair(make_pair(0, 0, 10, 10, 0, 11, 0, 10, 10, 0));
      send_pair(make_pair(0, 0, 10, 10, 0, -10, 0, 10, 10, 0));
      send_pair(make_pair(0, 0, 10, 10, 0, 0, 10, 10, 10, 0));
      send_pair(make_pair(0, 0, 10, 10, 0, 0, -10, 10, 10, 0));
      send_pair(make_pair(0, 0, 7, 5, 1, 7, 5, 7, 5, 1));
      send_pair(make_pair(0, 0, 4, 4, 0, 7, 8, 4, 4, 0));
   endtask

   task automatic test_extremes();
      int lo;
      int hi;
      lo = -(1 << (rod_pkg::POS_W - 1));
      hi = (1 << (rod_pkg::POS_W - 1)) - 1;
      send_pair(make_pair(lo, lo, 0, 0, 0, hi, hi, 0, 0, 0));
      send_pair(make_pair(lo, lo, 65535, 65535, 0, hi, hi, 65535, 65535, 1));
      send_pair(make_pair(hi, hi, 65535, 65535, 0, lo, lo, 65535, 65535, 1));
      send_pair(make_pair(5, -5, 0, 0, 1, 5, -5, 0, 0, 0));
      send_pair(make_pair(0, 0, 65535, 65535, 1, 1, -1, 65535, 65535, 1));
      send_pair(make_pair(lo, hi, 65535, 0, 1, lo, hi, 0, 65535, 0));
   endtask

   task automatic test_epsilon_limits();
      program_epsilon(EPS_ADDR, 32'h0000_0000);
      send_pair(make_pair(0, 0, 10, 10, 0, 10, 0, 10, 10, 0));
      send_pair(make_pair(5, -5, 0, 0, 1, 5, -5, 0, 0, 0));
      send_pair(make_pair(0, 0, 10, 10, 0, 0, 10, 10, 10, 0));
      program_epsilon(EPS_ADDR, 32'hFFFF_FFFF);
      send_pair(make_pair(0, 0, 10, 10, 0, 65544, 0, 10, 10, 0));
      send_pair(make_pair(0, 0, 10, 10, 0, 65545, 0, 10, 10, 0));
      send_pair(make_pair(0, 0, 65535, 65535, 0, -65534, -65535, 0, 0, 1));
      program_epsilon(UNMAPPED_ADDR, 32'h0000_0007);
      send_pair(make_pair(0, 0, 10, 10, 0, 20, 3, 10, 10, 0));
   endtask

   task automatic test_random_stream();
      int idle_pct[NUM_PHASES]  = '{30, 0, 50, 10, 0, 70, 20};
      int stall_pct[NUM_PHASES] = '{30, 50, 0, 10, 0, 60, 20};
      logic [rod_pkg::DATA_W-1:0] eps_word;
      int pick;
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         eps_word = $urandom;
         case (ph)
            0: eps_word[rod_pkg::EPS_W-1:0] = 16'd1;
            1: eps_word[rod_pkg::EPS_W-1:0] = 16'd0;
            2: eps_word[rod_pkg::EPS_W-1:0] = 16'hFFFF;
            3: eps_word[rod_pkg::EPS_W-1:0] = rod_pkg::EPS_W'($urandom_range(2, 50));
            5: eps_word[rod_pkg::EPS_W-1:0] = 16'd3;
            default: ;
         endcase
         program_epsilon(EPS_ADDR, eps_word);
         req_idle_pct = idle_pct[ph];
         rsp_stall_pct = stall_pct[ph];
         for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
            pick = $urandom_range(99);
            if (pick < 60) send_pair(near_pair(0));
            else if (pick < 75) send_pair(near_pair(1));
            else send_pair(full_random_pair());
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_bus.valid = 1'b0;
      drive_payload(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      rsp_bus.ready = 1'b0;
      stall_left = 0;
      req_idle_pct = 0;
      rsp_stall_pct = 0;
      fault_count = 0;
      touch_eps = rod_pkg::EPS_RESET;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_epsilon();
      test_extremes();
      test_epsilon_limits();
      test_random_stream();

      @(negedge clock);
      req_bus.valid = 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/rod_pkg.sv
src/rod_if.sv
src/rod_csr.sv
src/rod_geom.sv
src/rod_isqrt.sv
src/rod_skid.sv
src/rect_overlap_distance.sv
src/rod_checker.sv
test/testbench.sv
